// File: sv/assert_macros.svh
// Assertion macros shared by the key state detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: sv/mksd_pkg.sv
// Types, constants and helper functions of the MIDI key state detector.
package mksd_pkg;

	// Sizing
	localparam int MAX_DETECTORS = 16;
	localparam int MAX_ENTRIES   = 16;
	localparam int CHANNELS      = 16;
	localparam int NOTES         = 128;

	localparam int LEVEL_CELLS = CHANNELS * NOTES;
	localparam int STORE_CELLS = MAX_DETECTORS * MAX_ENTRIES;

	localparam int LVL_AW = (LEVEL_CELLS > 1) ? $clog2(LEVEL_CELLS) : 1;
	localparam int ST_AW  = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;
	localparam int DET_AW = (MAX_DETECTORS > 1) ? $clog2(MAX_DETECTORS) : 1;
	localparam int CNT_W  = $clog2(MAX_DETECTORS + 1);
	localparam int LEN_W  = $clog2(MAX_ENTRIES + 1);
	localparam int LVL_W  = 7;

	// Request codes
	localparam logic [1:0] REQ_MIDI  = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	// Message status bytes
	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
	localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
	localparam logic [7:0] STATUS_CONTROL  = 8'hB0;

	// Result codes
	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_FULL    = 2'd1;
	localparam logic [1:0] RES_INVALID = 2'd2;
	localparam logic [1:0] RES_BAD_ID  = 2'd3;

	// Configuration registers
	localparam logic       REG_PEDAL_THRESHOLD = 1'b0;
	localparam logic [7:0] PEDAL_RESET         = 8'd64;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] status_byte;
		logic [3:0] channel;
		logic [6:0] data0;
		logic [6:0] data1;
		logic       release_flag;
		logic       last_entry;
		logic [3:0] detector_select;
	} item_t;

	typedef struct packed {
		logic [1:0] result_code;
		logic [3:0] detector_id;
		logic       matched;
	} result_t;

	// One stored pattern entry
	typedef struct packed {
		logic       rel;
		logic       ctl;
		logic [3:0] channel;
		logic [6:0] number;
	} entry_t;

	localparam int ENT_W = $bits(entry_t);

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic q_len;
		logic scan;
		logic q_done;
		logic clr_step;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] req_type;
		logic       query_bad;
		logic       issue_done;
		logic       pipe_busy;
		logic       clr_last;
	} status_t;

	function automatic logic ch_ok(input logic [3:0] ch);
		return int'(ch) < CHANNELS;
	endfunction

	function automatic logic num_ok(input logic [6:0] num);
		return int'(num) < NOTES;
	endfunction

	function automatic logic [LVL_AW-1:0] lvl_addr(input logic [3:0] ch,
			input logic [6:0] num);
		return LVL_AW'(int'(ch) * NOTES + int'(num));
	endfunction

	function automatic logic [ST_AW-1:0] st_addr(input int det, input int ent);
		return ST_AW'(det * MAX_ENTRIES + ent);
	endfunction

endpackage

// File: sv/mksd_ram.sv
// Generic single write port RAM with a registered read port.
module mksd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word, both on the clock edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/mksd_ctrl.sv
// Sequencing state machine of the MIDI key state detector.
`include "assert_macros.svh"
module mksd_ctrl
	import mksd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_QLEN  = 6'b000100,
		S_SCAN  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_CLEAR = 6'b100000
	} ctl_state_t;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				case (st.req_type)
					REQ_QUERY: state_nxt = st.query_bad ? S_IDLE : S_QLEN;
					REQ_CLEAR: state_nxt = S_CLEAR;
					default:   state_nxt = S_IDLE;
				endcase
			end
			S_QLEN:  state_nxt = S_SCAN;
			S_SCAN: begin
				if (st.issue_done) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!st.pipe_busy) begin
					state_nxt = S_IDLE;
				end
			end
			S_CLEAR: begin
				if (st.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Hold state; run the clearing pass out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Drive commands
	always_comb begin
		busy         = (state_q != S_IDLE);
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && start;
		cmd.exec     = (state_q == S_EXEC);
		cmd.q_len    = (state_q == S_QLEN);
		cmd.scan     = (state_q == S_SCAN);
		cmd.q_done   = (state_q == S_DRAIN) && !st.pipe_busy;
		cmd.clr_step = (state_q == S_CLEAR);
	end

	`ASSERT_CLK(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "busy not raised after accept")
	`ASSERT_CLK(a_clear_holds, clk, arst_n, (state_q == S_CLEAR && !st.clr_last) |=> (state_q == S_CLEAR), "clearing pass left early")
	`ASSERT_CLK(a_drain_ends, clk, arst_n, cmd.q_done |=> !busy, "query did not return to idle")

endmodule

// File: sv/mksd_dp.sv
// Datapath of the MIDI key state detector: level tables, pattern store, query scan.
`include "assert_macros.svh"
module mksd_dp
	import mksd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  cmd_t       cmd,
	input  logic [7:0] thr,
	output status_t    st,
	output logic       done,
	output result_t    result
);

	// Captured request
	item_t req_q;

	// Pattern bookkeeping
	logic [CNT_W-1:0] det_cnt_q;
	logic [LEN_W-1:0] pend_len_q;
	logic             pend_err_q;

	// Query scan
	logic [LEN_W-1:0] n_q;
	logic [LEN_W-1:0] issue_idx_q;
	logic             valid_s1;
	logic             valid_s2;
	logic             ctl_s2;
	logic             rel_s2;
	logic             ok_s2;
	logic             match_q;

	// Clearing pass
	logic [LVL_AW-1:0] clr_idx_q;

	// Result register
	logic    done_q;
	result_t result_q;

	// RAM ports
	logic              key_we, ctl_we;
	logic [LVL_AW-1:0] lvl_waddr, lvl_raddr;
	logic [LVL_W-1:0]  key_wdata, ctl_wdata, key_rd, ctl_rd;
	logic              store_we;
	logic [ST_AW-1:0]  store_waddr, store_raddr;
	logic [ENT_W-1:0]  store_rd;
	logic              len_we;
	logic [DET_AW-1:0] len_waddr, len_raddr;
	logic [LEN_W-1:0]  len_rd;

	// Decode
	logic             ex_midi, ex_load, ex_query;
	logic             is_on, is_off, is_ctl, loc_ok;
	logic             full, room, ent_ok, err_nxt, commit, load_res, query_bad;
	logic [LEN_W-1:0] len_nxt;
	logic             issue;
	entry_t           ent_s1;
	logic [LVL_W-1:0] lvl;
	logic             pressed, holds;

	always_comb begin
		ex_midi   = cmd.exec && (req_q.req_type == REQ_MIDI);
		ex_load   = cmd.exec && (req_q.req_type == REQ_LOAD);
		ex_query  = cmd.exec && (req_q.req_type == REQ_QUERY);
		is_on     = (req_q.status_byte == STATUS_NOTE_ON);
		is_off    = (req_q.status_byte == STATUS_NOTE_OFF);
		is_ctl    = (req_q.status_byte == STATUS_CONTROL);
		loc_ok    = ch_ok(req_q.channel) && num_ok(req_q.data0);
		full      = (det_cnt_q >= CNT_W'(MAX_DETECTORS));
		room      = (pend_len_q < LEN_W'(MAX_ENTRIES));
		ent_ok    = (is_on || is_ctl) && loc_ok;
		err_nxt   = pend_err_q || !ent_ok || !room;
		len_nxt   = room ? pend_len_q + LEN_W'(1) : pend_len_q;
		commit    = ex_load && req_q.last_entry && !full && !err_nxt;
		load_res  = ex_load && req_q.last_entry;
		query_bad = (int'(req_q.detector_select) >= int'(det_cnt_q));
		issue     = cmd.scan && (issue_idx_q < n_q);
	end

	// Capture the request beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= item;
		end
	end

	// Level table writes: clearing pass or MIDI message
	always_comb begin
		lvl_waddr = cmd.clr_step ? clr_idx_q : lvl_addr(req_q.channel, req_q.data0);
		key_we    = cmd.clr_step || (ex_midi && loc_ok && (is_on || is_off));
		ctl_we    = cmd.clr_step || (ex_midi && loc_ok && is_ctl);
		key_wdata = (cmd.clr_step || !is_on) ? '0 : req_q.data1;
		ctl_wdata = cmd.clr_step ? '0 : req_q.data1;
	end

	// Advance the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= st.clr_last ? '0 : clr_idx_q + LVL_AW'(1);
		end
	end

	// Pattern store and length writes
	always_comb begin
		store_we    = ex_load && room && !full;
		store_waddr = st_addr(int'(det_cnt_q), int'(pend_len_q));
		len_we      = commit;
		len_waddr   = DET_AW'(det_cnt_q);
		len_raddr   = DET_AW'(req_q.detector_select);
		store_raddr = st_addr(int'(req_q.detector_select), int'(issue_idx_q));
	end

	// Track the pattern being loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_cnt_q  <= '0;
			pend_len_q <= '0;
			pend_err_q <= 1'b0;
		end else if (ex_load) begin
			if (req_q.last_entry) begin
				pend_len_q <= '0;
				pend_err_q <= 1'b0;
				if (commit) begin
					det_cnt_q <= det_cnt_q + CNT_W'(1);
				end
			end else begin
				pend_len_q <= len_nxt;
				pend_err_q <= err_nxt;
			end
		end
	end

	// Stage 1: entry read back, look up its level
	always_comb begin
		ent_s1    = entry_t'(store_rd);
		lvl_raddr = lvl_addr(ent_s1.channel, ent_s1.number);
	end

	// Stage 2: compare the level against the entry
	always_comb begin
		lvl     = ctl_s2 ? ctl_rd : key_rd;
		pressed = ({1'b0, lvl} >= thr);
		if (ctl_s2) begin
			holds = rel_s2 ? !pressed : pressed;
		end else begin
			holds = rel_s2 ? (lvl == '0) : (lvl != '0);
		end
	end

	// Scan control and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			issue_idx_q <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			match_q     <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (cmd.q_len) begin
				n_q         <= (len_rd > LEN_W'(MAX_ENTRIES)) ? LEN_W'(MAX_ENTRIES) : len_rd;
				issue_idx_q <= '0;
				match_q     <= 1'b0;
			end else begin
				if (issue) begin
					issue_idx_q <= issue_idx_q + LEN_W'(1);
				end
				if (valid_s2 && ok_s2 && holds) begin
					match_q <= 1'b1;
				end
			end
		end
	end

	// Carry entry kind into stage 2
	always_ff @(posedge clk) begin
		ctl_s2 <= ent_s1.ctl;
		rel_s2 <= ent_s1.rel;
		ok_s2  <= ch_ok(ent_s1.channel) && num_ok(ent_s1.number);
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= load_res || (ex_query && query_bad) || cmd.q_done;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load_res) begin
			result_q.matched     <= 1'b0;
			result_q.detector_id <= '0;
			if (full) begin
				result_q.result_code <= RES_FULL;
			end else if (err_nxt) begin
				result_q.result_code <= RES_INVALID;
			end else begin
				result_q.result_code <= RES_OK;
				result_q.detector_id <= 4'(det_cnt_q);
			end
		end else if (ex_query && query_bad) begin
			result_q.result_code <= RES_BAD_ID;
			result_q.detector_id <= '0;
			result_q.matched     <= 1'b0;
		end else if (cmd.q_done) begin
			result_q.result_code <= RES_OK;
			result_q.detector_id <= '0;
			result_q.matched     <= match_q;
		end
	end

	always_comb begin
		done          = done_q;
		result        = result_q;
		st.req_type   = req_q.req_type;
		st.query_bad  = query_bad;
		st.issue_done = !(issue_idx_q < n_q);
		st.pipe_busy  = valid_s1 || valid_s2;
		st.clr_last   = (clr_idx_q == LVL_AW'(LEVEL_CELLS - 1));
	end

	mksd_ram #(.WIDTH(LVL_W), .DEPTH(LEVEL_CELLS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (lvl_waddr),
		.wdata (key_wdata),
		.raddr (lvl_raddr),
		.rdata (key_rd)
	);

	mksd_ram #(.WIDTH(LVL_W), .DEPTH(LEVEL_CELLS)) u_ctl_ram (
		.clk   (clk),
		.we    (ctl_we),
		.waddr (lvl_waddr),
		.wdata (ctl_wdata),
		.raddr (lvl_raddr),
		.rdata (ctl_rd)
	);

	mksd_ram #(.WIDTH(ENT_W), .DEPTH(STORE_CELLS)) u_store_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata ({req_q.release_flag, is_ctl, req_q.channel, req_q.data0}),
		.raddr (store_raddr),
		.rdata (store_rd)
	);

	mksd_ram #(.WIDTH(LEN_W), .DEPTH(MAX_DETECTORS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_nxt),
		.raddr (len_raddr),
		.rdata (len_rd)
	);

	`ASSERT_CLK(a_done_single, clk, arst_n, done_q |=> !done_q, "result strobes back to back")
	`ASSERT_CLK(a_pipe_order, clk, arst_n, valid_s2 |-> $past(valid_s1), "stage 2 valid without stage 1")
	`ASSERT_ALWAYS(a_det_bound, clk, int'(det_cnt_q) <= MAX_DETECTORS, "detector count overflow")

endmodule

// File: sv/midi_key_state_pattern_detector.sv
// Top level of the MIDI key state detector: configuration register and core.
//
//  channel  | handshake             | beat
//  ---------+-----------------------+-------------------------------------------
//  request  | start, busy           | item (item_t), taken when start && !busy
//  result   | done                  | result (result_t), valid for one cycle
//  config   | psel, penable, pwrite | pedal_threshold at byte address 0
//
// A MIDI message or a pattern entry passes through the accept and the execute state.
// A query reads the detector length, then issues each entry through the pattern store
// read that feeds the level table read, and drains that pipeline before the result.
// A clear runs accept, execute, then clears one level table word per cycle.
// After reset the same clearing pass runs with busy high.
// The result goes out in the cycle after the last busy cycle; the receiver cannot stall.
module midi_key_state_pattern_detector
	import mksd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] thr_q;
	logic       cfg_we;
	cmd_t       cmd;
	status_t    st;

	// Decode the register write beat and the read data
	always_comb begin
		pready = 1'b1;
		cfg_we = psel && penable && pwrite && (paddr[2] == REG_PEDAL_THRESHOLD);
		prdata = (paddr[2] == REG_PEDAL_THRESHOLD) ? {24'b0, thr_q} : '0;
	end

	// Hold the pedal threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= PEDAL_RESET;
		end else if (cfg_we) begin
			thr_q <= pwdata[7:0];
		end
	end

	mksd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	mksd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.thr    (thr_q),
		.st     (st),
		.done   (done),
		.result (result)
	);

endmodule

// File: tb/midi_key_state_pattern_detector_test.sv
// Self-checking testbench for the MIDI key state pattern detector.
`timescale 1ns / 100ps

module midi_key_state_pattern_detector_test;
	import mksd_pkg::*;

	localparam int TOTAL_ITEMS = 1950;
	localparam int PHASES      = 8;
	localparam logic [2:0] THR_ADDR = 3'(4 * int'(REG_PEDAL_THRESHOLD));

	// Tracks key and controller levels and loaded patterns, predicts each answer
	class pattern_answer_model;
		bit [6:0] key_lvl [LEVEL_CELLS];
		bit [6:0] ctl_lvl [LEVEL_CELLS];
		entry_t   patterns [MAX_DETECTORS][MAX_ENTRIES];
		int       pat_len [MAX_DETECTORS];
		int       det_count;
		int       pend_len;
		bit       pend_bad;
		int       threshold;
		result_t  pending_answers[$];
		int       mismatches;
		int       answers_seen;
		int       hits;
		int       code_seen [4];

		function new();
			threshold = int'(PEDAL_RESET);
		endfunction

		function bit holds(entry_t e);
			int idx;
			int v;
			if (int'(e.channel) >= CHANNELS || int'(e.number) >= NOTES)
				return 1'b0;
			idx = int'(e.channel) * NOTES + int'(e.number);
			if (e.ctl) begin
				v = int'(ctl_lvl[idx]);
				return e.rel ? (v < threshold) : (v >= threshold);
			end
			v = int'(key_lvl[idx]);
			return e.rel ? (v == 0) : (v != 0);
		endfunction

		// Apply one accepted request and queue the answer it owes, if any
		function void take_request(item_t it);
			int idx;
			int n;
			bit ok;
			bit full;
			bit m;
			result_t r;
			idx = int'(it.channel) * NOTES + int'(it.data0);
			r = '0;
			case (it.req_type)
				REQ_MIDI: begin
					if (int'(it.channel) < CHANNELS && int'(it.data0) < NOTES) begin
						if (it.status_byte == STATUS_NOTE_ON)
							key_lvl[idx] = it.data1;
						else if (it.status_byte == STATUS_NOTE_OFF)
							key_lvl[idx] = '0;
						else if (it.status_byte == STATUS_CONTROL)
							ctl_lvl[idx] = it.data1;
					end
				end
				REQ_LOAD: begin
					ok = (it.status_byte == STATUS_NOTE_ON || it.status_byte == STATUS_CONTROL)
						&& int'(it.channel) < CHANNELS && int'(it.data0) < NOTES;
					full = det_count >= MAX_DETECTORS;
					if (!ok)
						pend_bad = 1'b1;
					if (pend_len >= MAX_ENTRIES) begin
						pend_bad = 1'b1;
					end else begin
						if (!full)
							patterns[det_count][pend_len] = '{rel: it.release_flag,
								ctl: (it.status_byte == STATUS_CONTROL),
								channel: it.channel, number: it.data0};
						pend_len++;
					end
					if (it.last_entry) begin
						if (full) begin
							r.result_code = RES_FULL;
						end else if (pend_bad) begin
							r.result_code = RES_INVALID;
						end else begin
							r.result_code = RES_OK;
							r.detector_id = 4'(det_count);
							pat_len[det_count] = pend_len;
							det_count++;
						end
						pending_answers.push_back(r);
						pend_len = 0;
						pend_bad = 1'b0;
					end
				end
				REQ_QUERY: begin
					if (int'(it.detector_select) >= det_count) begin
						r.result_code = RES_BAD_ID;
					end else begin
						n = pat_len[it.detector_select];
						if (n > MAX_ENTRIES)
							n = MAX_ENTRIES;
						m = 1'b0;
						for (int i = 0; i < n; i++)
							if (holds(patterns[it.detector_select][i]))
								m = 1'b1;
						r.result_code = RES_OK;
						r.matched = m;
					end
					pending_answers.push_back(r);
				end
				default: begin
					foreach (key_lvl[i]) begin
						key_lvl[i] = '0;
						ctl_lvl[i] = '0;
					end
				end
			endcase
		endfunction

		// Compare one answer beat against the oldest one owed
		function void check_answer(result_t got);
			result_t want;
			answers_seen++;
			code_seen[got.result_code]++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected answer, expected none, got code %0d id %0d matched %0b",
					$time, got.result_code, got.detector_id, got.matched);
				return;
			end
			want = pending_answers.pop_front();
			if (want.matched)
				hits++;
			if (got.result_code !== want.result_code) begin
				mismatches++;
				$display("%0t: result_code expected %0d, got %0d",
					$time, want.result_code, got.result_code);
			end
			if (got.detector_id !== want.detector_id) begin
				mismatches++;
				$display("%0t: detector_id expected %0d, got %0d",
					$time, want.detector_id, got.detector_id);
			end
			if (got.matched !== want.matched) begin
				mismatches++;
				$display("%0t: matched expected %0b, got %0b",
					$time, want.matched, got.matched);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       req_beat = '0;
	logic        done;
	result_t     res_beat;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pattern_answer_model answers = new();
	int sent;
	int counted;
	int burst_left;
	int clears;

	midi_key_state_pattern_detector u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(req_beat),
		.done(done),
		.result(res_beat),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check every answer beat at the edge that ends it
	always @(posedge clk) begin
		if (arst_n && done)
			answers.check_answer(res_beat);
	end

	// Hard stop in case the block hangs
	initial begin
		#250_000_000;
		$display("Verification failed");
		$finish;
	end

	// Idle length before the next beat: mostly short, some long, zero in bursts
	function int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function item_t rand_item();
		return $bits(item_t)'({$urandom(), $urandom()});
	endfunction

	function item_t mk(logic [1:0] req, logic [7:0] status, int ch, int d0, int d1,
			bit rel, bit last, int sel);
		item_t it;
		it = rand_item();
		it.req_type = req;
		it.status_byte = status;
		it.channel = 4'(ch);
		it.data0 = 7'(d0);
		it.data1 = 7'(d1);
		it.release_flag = rel;
		it.last_entry = last;
		it.detector_select = 4'(sel);
		return it;
	endfunction

	// Favor a few channels and notes so patterns and messages meet
	function logic [3:0] pick_channel();
		if ($urandom_range(0, 3) != 0)
			return 4'($urandom_range(0, 3));
		return 4'($urandom_range(0, 15));
	endfunction

	function logic [6:0] pick_number();
		if ($urandom_range(0, 3) != 0)
			return 7'($urandom_range(60, 67));
		return 7'($urandom_range(0, 127));
	endfunction

	function item_t midi_msg();
		item_t it;
		int r;
		int v;
		it = rand_item();
		it.req_type = REQ_MIDI;
		it.channel = pick_channel();
		it.data0 = pick_number();
		r = $urandom_range(0, 99);
		if (r < 40) begin
			it.status_byte = STATUS_NOTE_ON;
			if ($urandom_range(0, 4) == 0)
				it.data1 = '0;
		end else if (r < 65) begin
			it.status_byte = STATUS_NOTE_OFF;
		end else if (r < 90) begin
			it.status_byte = STATUS_CONTROL;
			// land close to the threshold half of the time
			if ($urandom_range(0, 1) == 0) begin
				v = answers.threshold - 2 + int'($urandom_range(0, 3));
				if (v < 0)
					v = 0;
				if (v > 127)
					v = 127;
				it.data1 = 7'(v);
			end
		end
		return it;
	endfunction

	function item_t query_beat();
		item_t it;
		it = rand_item();
		it.req_type = REQ_QUERY;
		if (answers.det_count > 0 && $urandom_range(0, 4) != 0)
			it.detector_select = 4'($urandom_range(0, answers.det_count - 1));
		return it;
	endfunction

	// Drive one beat and hold it until the block takes it
	task send_beat(input item_t it, input bit counts);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			req_beat = rand_item();
			repeat (gap) @(negedge clk);
		end
		req_beat = it;
		start = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		answers.take_request(it);
		sent++;
		if (counts)
			counted++;
	endtask

	// Drop start and wait until every answer is in and the block is idle
	task settle();
		@(negedge clk);
		start = 1'b0;
		while (answers.pending_answers.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task read_threshold(input logic [7:0] want);
		logic [31:0] got;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = THR_ADDR;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (got !== {24'd0, want}) begin
			answers.mismatches++;
			$display("%0t: pedal_threshold read expected %0d, got %0d", $time, want, got);
		end
	endtask

	task set_threshold(input logic [7:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = THR_ADDR;
		pwdata = {24'd0, val};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		answers.threshold = int'(val);
		read_threshold(val);
	endtask

	// One pattern load: mostly well formed under the detector budget, else mostly broken
	task load_pattern();
		int budget;
		int mode;
		int n;
		int bad_at;
		item_t it;
		budget = (counted * (MAX_DETECTORS + 4)) / TOTAL_ITEMS;
		if (answers.det_count >= MAX_DETECTORS)
			mode = $urandom_range(0, 2);
		else if (answers.det_count < budget && $urandom_range(0, 9) < 7)
			mode = 0;
		else
			mode = $urandom_range(1, 2);
		if (mode == 1)
			n = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 4);
		else if ($urandom_range(0, 9) < 7)
			n = $urandom_range(1, 4);
		else
			n = $urandom_range(5, MAX_ENTRIES);
		bad_at = (mode == 2) ? $urandom_range(0, n - 1) : -1;
		for (int i = 0; i < n; i++) begin
			it = rand_item();
			it.req_type = REQ_LOAD;
			it.status_byte = $urandom_range(0, 1) ? STATUS_CONTROL : STATUS_NOTE_ON;
			it.channel = pick_channel();
			it.data0 = pick_number();
			it.last_entry = (i == n - 1);
			if (i == bad_at) begin
				if ($urandom_range(0, 1) == 0) begin
					it.status_byte = STATUS_NOTE_OFF;
				end else begin
					it.status_byte = 8'($urandom());
					if (it.status_byte == STATUS_NOTE_ON || it.status_byte == STATUS_CONTROL)
						it.status_byte ^= 8'h01;
				end
			end
			send_beat(it, 1'b1);
		end
	endtask

	initial begin
		int thr_plan [PHASES];
		int phase;
		int next_phase;
		int r;
		item_t it;

		thr_plan = '{0, 128, 127, 1, 64, 100, 32, 64};
		thr_plan[4] = $urandom_range(0, 128);
		thr_plan[6] = $urandom_range(0, 128);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		read_threshold(PEDAL_RESET);

		// Directed: extremes, every request kind, ignored status, errors
		send_beat(mk(REQ_QUERY, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_MIDI, STATUS_NOTE_ON, 0, 60, 100, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_MIDI, STATUS_NOTE_ON, 15, 127, 127, 1, 1, 15), 1'b0);
		send_beat(mk(REQ_MIDI, STATUS_CONTROL, 0, 64, 127, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_MIDI, STATUS_CONTROL, 3, 0, 63, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_MIDI, STATUS_NOTE_OFF, 0, 60, 55, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_MIDI, 8'hF0, 1, 0, 127, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_MIDI, STATUS_NOTE_ON, 2, 5, 0, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_LOAD, STATUS_NOTE_ON, 15, 127, 0, 0, 1, 0), 1'b0);
		send_beat(mk(REQ_LOAD, STATUS_CONTROL, 0, 64, 0, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_LOAD, STATUS_NOTE_ON, 0, 60, 0, 1, 1, 0), 1'b0);
		send_beat(mk(REQ_LOAD, STATUS_NOTE_OFF, 1, 1, 0, 0, 1, 0), 1'b0);
		send_beat(mk(REQ_LOAD, STATUS_CONTROL, 3, 0, 0, 1, 1, 0), 1'b0);
		send_beat(mk(REQ_QUERY, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_QUERY, 8'h00, 0, 0, 0, 0, 0, 1), 1'b0);
		send_beat(mk(REQ_QUERY, 8'h00, 0, 0, 0, 0, 0, 2), 1'b0);
		send_beat(mk(REQ_QUERY, 8'h00, 0, 0, 0, 0, 0, 15), 1'b0);
		send_beat(mk(REQ_QUERY, 8'h00, 0, 0, 0, 0, 0, 3), 1'b0);
		send_beat(mk(REQ_CLEAR, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_QUERY, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0);
		send_beat(mk(REQ_QUERY, 8'h00, 0, 0, 0, 0, 0, 1), 1'b0);
		send_beat(mk(REQ_LOAD, STATUS_CONTROL, 0, 0, 0, 0, 1, 0), 1'b0);
		send_beat(mk(REQ_QUERY, 8'h00, 0, 0, 0, 0, 0, 3), 1'b0);

		// Random traffic in phases, each with its own pedal threshold
		phase = 0;
		next_phase = 0;
		while (counted < TOTAL_ITEMS) begin
			if (counted >= next_phase && phase < PHASES) begin
				settle();
				set_threshold(8'(thr_plan[phase]));
				phase++;
				next_phase += TOTAL_ITEMS / PHASES;
			end
			r = $urandom_range(0, 999);
			if (r < 450) begin
				send_beat(midi_msg(), 1'b1);
			end else if (r < 730) begin
				send_beat(query_beat(), 1'b1);
			end else if (r < 880) begin
				load_pattern();
			end else if (r < 898) begin
				clears++;
				it = rand_item();
				it.req_type = REQ_CLEAR;
				send_beat(it, 1'b1);
			end else if (r < 905) begin
				settle();
			end else if (r < 985) begin
				// fully random message, usually an ignored status
				it = rand_item();
				it.req_type = REQ_MIDI;
				send_beat(it, 1'b0);
			end else begin
				// stray load entry with random content
				it = rand_item();
				it.req_type = REQ_LOAD;
				send_beat(it, 1'b1);
			end
		end

		settle();
		if (answers.pending_answers.size() != 0) begin
			answers.mismatches++;
			$display("%0t: %0d answers expected but never seen",
				$time, answers.pending_answers.size());
		end
		$display("Run: %0d requests, %0d answers checked, %0d detectors loaded, %0d clears",
			sent, answers.answers_seen, answers.det_count, clears);
		$display("Answers: ok %0d, full %0d, invalid %0d, bad id %0d; queries matched %0d",
			answers.code_seen[0], answers.code_seen[1], answers.code_seen[2],
			answers.code_seen[3], answers.hits);
		if (answers.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
